### hw/rtl/tsmw_pkg.sv
// tsmw_pkg: shared constants, result codes and types of the tar stream member walker
// used by tsmw_parse, tsmw_out_fifo and tar_stream_member_walker; depends on nothing
`timescale 1ns / 1ps

package tsmw_pkg;

  // tar block geometry
  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned POS_W       = $clog2(BLOCK_BYTES);
  localparam int unsigned NAME_BYTES  = 100;
  localparam int unsigned NAME_W      = 7;
  localparam int unsigned SIZE_OFFSET = 124;
  localparam int unsigned SIZE_DIGITS = 12;
  localparam int unsigned TYPE_OFFSET = 156;
  localparam int unsigned SIZE_W      = 36;

  // stream length tracking, saturates at two blocks
  localparam int unsigned TWO_BLOCKS  = 2 * BLOCK_BYTES;
  localparam int unsigned TBS_W       = $clog2(TWO_BLOCKS) + 1;

  // ascii characters seen in a header
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;

  // result queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH) + 1;

  // result kinds
  typedef enum logic [2:0] {
    KIND_NAME    = 3'd0,
    KIND_VERDICT = 3'd1,
    KIND_DATA    = 3'd2,
    KIND_END     = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_e;

  // stream error codes
  localparam logic ERR_OVERRUN = 1'b0;
  localparam logic ERR_SHORT   = 1'b1;

  // one result word
  typedef struct packed {
    kind_e              kind;
    logic [7:0]         byte_value;
    logic               accepted;
    logic [SIZE_W-1:0]  member_size;
    logic [NAME_W-1:0]  name_length;
    logic               last_of_member;
    logic               error_code;
  } result_t;

  // up to two results produced by one input byte
  typedef struct packed {
    logic    a_valid;
    result_t a;
    logic    b_valid;
    result_t b;
  } push_t;

endpackage

### hw/rtl/tsmw_parse.sv
// tsmw_parse: header walk state and per-byte result generation
// depends on tsmw_pkg
`timescale 1ns / 1ps

module tsmw_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_acc_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output tsmw_pkg::push_t     push_o
);

  // walker phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_PAD    = 2'd2;
  localparam logic [1:0] PH_ENDED  = 2'd3;

  localparam int unsigned POS_W  = tsmw_pkg::POS_W;
  localparam int unsigned SIZE_W = tsmw_pkg::SIZE_W;
  localparam int unsigned NAME_W = tsmw_pkg::NAME_W;
  localparam int unsigned TBS_W  = tsmw_pkg::TBS_W;

  logic [POS_W-1:0]  pos_q, pos_d, pos_inc;
  logic [1:0]        phase_q, phase_d;
  logic [NAME_W-1:0] name_cnt_q, name_cnt_d;
  logic              name_end_q, name_end_d;
  logic [SIZE_W-1:0] size_acc_q, size_acc_d;
  logic              size_stop_q, size_stop_d;
  logic [7:0]        type_q, type_d;
  logic              all_zero_q, all_zero_d, all_zero_nxt;
  logic [SIZE_W-1:0] remain_q, remain_d;
  logic              macc_q, macc_d;
  logic [TBS_W-1:0]  tbs_q, tbs_d;

  logic              short_stream;
  logic              owed;
  logic              in_size_field;
  logic              is_octal;
  logic              type_ok;
  logic              verdict_acc;
  logic              main_v;
  tsmw_pkg::result_t main_r;
  logic              err_v;
  tsmw_pkg::result_t err_r;

  // per-byte next state and results
  always_comb begin
    pos_d       = pos_q;
    phase_d     = phase_q;
    name_cnt_d  = name_cnt_q;
    name_end_d  = name_end_q;
    size_acc_d  = size_acc_q;
    size_stop_d = size_stop_q;
    type_d      = type_q;
    all_zero_d  = all_zero_q;
    remain_d    = remain_q;
    macc_d      = macc_q;
    owed        = 1'b0;
    main_v      = 1'b0;
    main_r      = '0;
    err_v       = 1'b0;
    err_r       = '0;

    pos_inc      = pos_q + 1'b1;
    tbs_d        = (tbs_q < TBS_W'(tsmw_pkg::TWO_BLOCKS)) ? tbs_q + 1'b1 : tbs_q;
    short_stream = tbs_d < TBS_W'(tsmw_pkg::TWO_BLOCKS);

    in_size_field = (pos_q >= POS_W'(tsmw_pkg::SIZE_OFFSET)) &&
                    (pos_q <  POS_W'(tsmw_pkg::SIZE_OFFSET + tsmw_pkg::SIZE_DIGITS));
    is_octal      = (data_byte_i >= tsmw_pkg::CH_ZERO) && (data_byte_i <= tsmw_pkg::CH_SEVEN);
    all_zero_nxt  = all_zero_q && (data_byte_i == tsmw_pkg::CH_NUL);
    type_ok       = (type_q == tsmw_pkg::CH_ZERO) || (type_q == tsmw_pkg::CH_NUL) ||
                    (type_q == tsmw_pkg::CH_SEVEN);
    verdict_acc   = (name_cnt_q != '0) && type_ok && (size_acc_q != '0);

    unique case (phase_q)
      PH_HEADER: begin
        // name bytes up to the first nul
        if ((pos_q < POS_W'(tsmw_pkg::NAME_BYTES)) && !name_end_q) begin
          if (data_byte_i != tsmw_pkg::CH_NUL) begin
            main_v            = 1'b1;
            main_r.kind       = tsmw_pkg::KIND_NAME;
            main_r.byte_value = data_byte_i;
            name_cnt_d        = name_cnt_q + 1'b1;
          end else begin
            name_end_d = 1'b1;
          end
        end
        // octal size digits, nul and space skipped
        if (in_size_field && !size_stop_q && (data_byte_i != tsmw_pkg::CH_NUL) &&
            (data_byte_i != tsmw_pkg::CH_SPACE)) begin
          if (is_octal) begin
            size_acc_d = {size_acc_q[SIZE_W-4:0], data_byte_i[2:0]};
          end else begin
            size_stop_d = 1'b1;
          end
        end
        if (pos_q == POS_W'(tsmw_pkg::TYPE_OFFSET)) begin
          type_d = data_byte_i;
        end
        all_zero_d = all_zero_nxt;
        // end of header block: verdict or end of archive
        if (pos_q == POS_W'(tsmw_pkg::BLOCK_BYTES - 1)) begin
          main_v = 1'b1;
          if (all_zero_nxt) begin
            main_r.kind = tsmw_pkg::KIND_END;
            phase_d     = PH_ENDED;
          end else begin
            main_r.kind        = tsmw_pkg::KIND_VERDICT;
            main_r.accepted    = verdict_acc;
            main_r.member_size = size_acc_q;
            main_r.name_length = name_cnt_q;
            macc_d             = verdict_acc;
            remain_d           = size_acc_q;
            phase_d            = (size_acc_q != '0) ? PH_DATA : PH_HEADER;
            owed               = verdict_acc;
          end
          name_cnt_d  = '0;
          name_end_d  = 1'b0;
          size_acc_d  = '0;
          size_stop_d = 1'b0;
          type_d      = '0;
          all_zero_d  = 1'b1;
        end
        pos_d = pos_inc;
      end
      PH_DATA: begin
        // member data, forwarded only when kept
        if (macc_q) begin
          main_v                = 1'b1;
          main_r.kind           = tsmw_pkg::KIND_DATA;
          main_r.byte_value     = data_byte_i;
          main_r.last_of_member = (remain_q == SIZE_W'(1));
        end
        remain_d = remain_q - 1'b1;
        pos_d    = pos_inc;
        if (remain_d == '0) begin
          phase_d = (pos_inc == '0) ? PH_HEADER : PH_PAD;
        end else begin
          owed = macc_q;
        end
      end
      PH_PAD: begin
        pos_d = pos_inc;
        if (pos_inc == '0) begin
          phase_d = PH_HEADER;
        end
      end
      PH_ENDED: begin
        // everything ignored until the stream closes
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase

    // stream close: error report and return to reset state
    if (last_byte_i) begin
      if (short_stream || owed) begin
        err_v            = 1'b1;
        err_r.kind       = tsmw_pkg::KIND_ERROR;
        err_r.error_code = short_stream ? tsmw_pkg::ERR_SHORT : tsmw_pkg::ERR_OVERRUN;
      end
      pos_d       = '0;
      phase_d     = PH_HEADER;
      name_cnt_d  = '0;
      name_end_d  = 1'b0;
      size_acc_d  = '0;
      size_stop_d = 1'b0;
      type_d      = '0;
      all_zero_d  = 1'b1;
      remain_d    = '0;
      macc_d      = 1'b0;
      tbs_d       = '0;
    end
  end

  // pack results so that the first valid one sits in slot a
  always_comb begin
    push_o = '0;
    if (in_acc_i) begin
      if (main_v) begin
        push_o.a_valid = 1'b1;
        push_o.a       = main_r;
        push_o.b_valid = err_v;
        push_o.b       = err_r;
      end else begin
        push_o.a_valid = err_v;
        push_o.a       = err_r;
      end
    end
  end

  // walker state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      phase_q     <= PH_HEADER;
      name_cnt_q  <= '0;
      name_end_q  <= 1'b0;
      size_acc_q  <= '0;
      size_stop_q <= 1'b0;
      type_q      <= '0;
      all_zero_q  <= 1'b1;
      remain_q    <= '0;
      macc_q      <= 1'b0;
      tbs_q       <= '0;
    end else if (in_acc_i) begin
      pos_q       <= pos_d;
      phase_q     <= phase_d;
      name_cnt_q  <= name_cnt_d;
      name_end_q  <= name_end_d;
      size_acc_q  <= size_acc_d;
      size_stop_q <= size_stop_d;
      type_q      <= type_d;
      all_zero_q  <= all_zero_d;
      remain_q    <= remain_d;
      macc_q      <= macc_d;
      tbs_q       <= tbs_d;
    end
  end

`ifndef SYNTHESIS
  // a data phase always has bytes left to walk
  a_data_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (remain_q != '0))
    else $error("data phase with no bytes remaining");

  // the name count never passes the name field
  a_name_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    name_cnt_q <= NAME_W'(tsmw_pkg::NAME_BYTES))
    else $error("name count beyond name field");

  // closing byte returns the walker to its start
  a_close_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc_i && last_byte_i) |=> (pos_q == '0 && phase_q == PH_HEADER && tbs_q == '0))
    else $error("walker not back at start after final byte");

  // an error result only comes with the closing byte
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.b_valid || (push_o.a_valid && push_o.a.kind == tsmw_pkg::KIND_ERROR))
      |-> (in_acc_i && last_byte_i))
    else $error("stream error without final byte");
`endif

endmodule

### hw/rtl/tsmw_out_fifo.sv
// tsmw_out_fifo: four-entry result queue, two writes and one read per cycle unless the reader stalls
// depends on tsmw_pkg
`timescale 1ns / 1ps

module tsmw_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsmw_pkg::push_t   push_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output tsmw_pkg::result_t word_o
);

  localparam int unsigned PTR_W = tsmw_pkg::FIFO_PTR_W;
  localparam int unsigned CNT_W = tsmw_pkg::FIFO_CNT_W;

  tsmw_pkg::result_t mem_q [tsmw_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PTR_W-1:0]  wr_ptr_b;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  push_n;
  logic              pop;

  assign push_n   = CNT_W'(push_i.a_valid) + CNT_W'(push_i.b_valid);
  assign wr_ptr_b = wr_ptr_q + PTR_W'(push_i.a_valid);
  assign pop      = valid_o && !stall_i;
  assign valid_o  = (count_q != '0);
  assign word_o   = mem_q[rd_ptr_q];
  // room is needed for the two results one byte can cause
  assign full_o   = count_q > CNT_W'(tsmw_pkg::FIFO_DEPTH - 2);

  // storage writes
  always_ff @(posedge clk_i) begin
    if (push_i.a_valid) begin
      mem_q[wr_ptr_q] <= push_i.a;
    end
    if (push_i.b_valid) begin
      mem_q[wr_ptr_b] <= push_i.b;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      count_q  <= count_q + push_n - CNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  // fill count stays within the queue
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(tsmw_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // a second slot is only filled together with the first
  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.b_valid |-> push_i.a_valid)
    else $error("second result pushed without first");

  // nothing is pushed while the queue reports full
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> (push_n == '0))
    else $error("result pushed into full queue");
`endif

endmodule

### hw/rtl/tar_stream_member_walker.sv
// tar_stream_member_walker: top level of the tar header walker
// depends on tsmw_pkg, tsmw_parse and tsmw_out_fifo
`timescale 1ns / 1ps

// Takes an uncompressed tar stream one byte per word and walks its 512-byte
// header blocks: name bytes, header verdicts, data bytes of kept members, an
// end-of-archive mark and stream errors come out as result words, one per
// word on the output. A byte is decoded against the walker state in the cycle
// it is accepted, and its results are registered in the result queue. A byte
// can cause up to two results; they go into a four-entry result queue, and the
// input stalls while fewer than two entries are free, so the input runs at one
// byte per cycle as long as each byte yields at most one result and the output
// is drained. No clearing pass is needed after reset.
module tar_stream_member_walker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    kind_o,
  output logic [7:0]                    byte_value_o,
  output logic                          accepted_o,
  output logic [tsmw_pkg::SIZE_W-1:0]   member_size_o,
  output logic [tsmw_pkg::NAME_W-1:0]   name_length_o,
  output logic                          last_of_member_o,
  output logic                          error_code_o
);

  logic              in_acc;
  logic              full;
  tsmw_pkg::push_t   push;
  tsmw_pkg::result_t word;

  // input handshake
  assign in_stall_o = full;
  assign in_acc     = in_valid_i && !full;

  // header walk
  tsmw_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_acc_i    (in_acc),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push)
  );

  // result queue
  tsmw_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .word_o  (word)
  );

  // result fields
  assign kind_o           = word.kind;
  assign byte_value_o     = word.byte_value;
  assign accepted_o       = word.accepted;
  assign member_size_o    = word.member_size;
  assign name_length_o    = word.name_length;
  assign last_of_member_o = word.last_of_member;
  assign error_code_o     = word.error_code;

endmodule

### tb/sv/tb_top.sv
// tb_top: self-checking testbench of the tar stream member walker
// builds tar streams, drives them byte by byte and checks every result word
// depends on tsmw_pkg and tar_stream_member_walker
`timescale 1ns / 1ps

module tb_top;

  // geometry and widths shared with the block
  localparam int unsigned BLOCK_BYTES = tsmw_pkg::BLOCK_BYTES;
  localparam int unsigned NAME_BYTES  = tsmw_pkg::NAME_BYTES;
  localparam int unsigned SIZE_OFFSET = tsmw_pkg::SIZE_OFFSET;
  localparam int unsigned SIZE_DIGITS = tsmw_pkg::SIZE_DIGITS;
  localparam int unsigned TYPE_OFFSET = tsmw_pkg::TYPE_OFFSET;
  localparam int unsigned TWO_BLOCKS  = tsmw_pkg::TWO_BLOCKS;
  localparam int unsigned SIZE_W      = tsmw_pkg::SIZE_W;
  localparam int unsigned NAME_W      = tsmw_pkg::NAME_W;
  localparam int unsigned POS_W       = tsmw_pkg::POS_W;
  localparam int unsigned TBS_W       = tsmw_pkg::TBS_W;

  localparam logic [SIZE_W-1:0] SIZE_ALL_ONES = '1;
  localparam int PHASE_BYTES  = 400;
  localparam int HOLD_START   = 600;
  localparam int HOLD_SPACING = 250;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  // ways of writing the octal size field
  typedef enum int {SZ_PLAIN, SZ_SPACED, SZ_FULL, SZ_STOPPED, SZ_NOISE} size_fmt_e;

  // where the walker stands in the stream
  typedef enum logic [1:0] {WALK_HEADER, WALK_DATA, WALK_PAD, WALK_ENDED} walk_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        data_byte_i = 8'h00;
  logic              last_byte_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [2:0]        kind_o;
  logic [7:0]        byte_value_o;
  logic              accepted_o;
  logic [SIZE_W-1:0] member_size_o;
  logic [NAME_W-1:0] name_length_o;
  logic              last_of_member_o;
  logic              error_code_o;

  tar_stream_member_walker dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .byte_value_o     (byte_value_o),
    .accepted_o       (accepted_o),
    .member_size_o    (member_size_o),
    .name_length_o    (name_length_o),
    .last_of_member_o (last_of_member_o),
    .error_code_o     (error_code_o)
  );

  // clock, 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [7:0]          build_q [$];
  stream_word_t        stream_words [$];
  tsmw_pkg::result_t   expected_words [$];
  tsmw_pkg::result_t   want;
  stream_word_t        next_word;
  logic                byte_taken = 1'b0;
  int                  bytes_accepted = 0;
  int                  mismatches = 0;
  int                  hold_left = 0;
  int                  holds_done = 0;
  longint              cycle_count = 0;
  longint              cycle_limit = 64'd5000000;

  // walker state mirrored by the predictor
  logic [POS_W-1:0]  blk_pos;
  walk_phase_e       walk_phase;
  logic [NAME_W-1:0] name_len;
  logic              name_done;
  logic [SIZE_W-1:0] size_acc;
  logic              size_stop;
  logic [7:0]        type_seen;
  logic              blk_zero;
  logic [SIZE_W-1:0] data_left;
  logic              keep_member;
  logic [TBS_W-1:0]  seen_bytes;

  task automatic walker_reset();
    blk_pos     = '0;
    walk_phase  = WALK_HEADER;
    name_len    = '0;
    name_done   = 1'b0;
    size_acc    = '0;
    size_stop   = 1'b0;
    type_seen   = tsmw_pkg::CH_NUL;
    blk_zero    = 1'b1;
    data_left   = '0;
    keep_member = 1'b0;
    seen_bytes  = '0;
  endtask

  task automatic expect_word(input tsmw_pkg::kind_e k, input logic [7:0] v,
                             input logic acc, input logic [SIZE_W-1:0] sz,
                             input logic [NAME_W-1:0] nl, input logic lm, input logic ec);
    tsmw_pkg::result_t w;
    w.kind           = k;
    w.byte_value     = v;
    w.accepted       = acc;
    w.member_size    = sz;
    w.name_length    = nl;
    w.last_of_member = lm;
    w.error_code     = ec;
    expected_words.push_back(w);
  endtask

  // advance the walker by one stream byte and queue the words it yields
  task automatic walk_tar_byte(input logic [7:0] b, input logic is_last);
    logic owed;
    logic type_ok;
    logic keep;
    owed = 1'b0;
    if (seen_bytes < TWO_BLOCKS) seen_bytes = seen_bytes + 1'b1;
    case (walk_phase)
      WALK_HEADER: begin
        // name bytes go out until the first nul
        if (blk_pos < NAME_BYTES && !name_done) begin
          if (b != tsmw_pkg::CH_NUL) begin
            expect_word(tsmw_pkg::KIND_NAME, b, 1'b0, '0, '0, 1'b0, 1'b0);
            name_len = name_len + 1'b1;
          end else begin
            name_done = 1'b1;
          end
        end
        // octal size, nul and space skipped, other non-digits stop it
        if (blk_pos >= SIZE_OFFSET && blk_pos < SIZE_OFFSET + SIZE_DIGITS && !size_stop &&
            b != tsmw_pkg::CH_NUL && b != tsmw_pkg::CH_SPACE) begin
          if (b >= tsmw_pkg::CH_ZERO && b <= tsmw_pkg::CH_SEVEN)
            size_acc = (size_acc << 3) + (b - tsmw_pkg::CH_ZERO);
          else size_stop = 1'b1;
        end
        if (blk_pos == TYPE_OFFSET) type_seen = b;
        if (b != tsmw_pkg::CH_NUL) blk_zero = 1'b0;
        // verdict or end mark on the last header byte
        if (blk_pos == BLOCK_BYTES - 1) begin
          if (blk_zero) begin
            expect_word(tsmw_pkg::KIND_END, 8'h00, 1'b0, '0, '0, 1'b0, 1'b0);
            walk_phase = WALK_ENDED;
          end else begin
            type_ok = type_seen == tsmw_pkg::CH_ZERO || type_seen == tsmw_pkg::CH_NUL ||
                      type_seen == tsmw_pkg::CH_SEVEN;
            keep = name_len != 0 && type_ok && size_acc != 0;
            expect_word(tsmw_pkg::KIND_VERDICT, 8'h00, keep, size_acc, name_len, 1'b0, 1'b0);
            keep_member = keep;
            data_left   = size_acc;
            walk_phase  = (size_acc != 0) ? WALK_DATA : WALK_HEADER;
            owed        = keep;
          end
          name_len  = '0;
          name_done = 1'b0;
          size_acc  = '0;
          size_stop = 1'b0;
          type_seen = tsmw_pkg::CH_NUL;
          blk_zero  = 1'b1;
        end
        blk_pos = blk_pos + 1'b1;
      end
      WALK_DATA: begin
        if (keep_member)
          expect_word(tsmw_pkg::KIND_DATA, b, 1'b0, '0, '0, data_left == 1, 1'b0);
        data_left = data_left - 1'b1;
        blk_pos   = blk_pos + 1'b1;
        if (data_left == 0) walk_phase = (blk_pos == 0) ? WALK_HEADER : WALK_PAD;
        else owed = keep_member;
      end
      WALK_PAD: begin
        blk_pos = blk_pos + 1'b1;
        if (blk_pos == 0) walk_phase = WALK_HEADER;
      end
      default: ;
    endcase
    // stream close: at most one error, short stream first
    if (is_last) begin
      if (seen_bytes < TWO_BLOCKS)
        expect_word(tsmw_pkg::KIND_ERROR, 8'h00, 1'b0, '0, '0, 1'b0, tsmw_pkg::ERR_SHORT);
      else if (owed)
        expect_word(tsmw_pkg::KIND_ERROR, 8'h00, 1'b0, '0, '0, 1'b0, tsmw_pkg::ERR_OVERRUN);
      walker_reset();
    end
  endtask

  function automatic logic [7:0] oct_digit(input logic [SIZE_W-1:0] v, input int pos);
    return tsmw_pkg::CH_ZERO + 8'((v >> (3 * pos)) & 7);
  endfunction

  task automatic put_random(input int n);
    for (int i = 0; i < n; i++) build_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_zero_blocks(input int n);
    for (int i = 0; i < n * BLOCK_BYTES; i++) build_q.push_back(8'h00);
  endtask

  // one 512-byte header: name, size field in the given form and type byte
  task automatic put_header(input int nlen, input logic [7:0] typ, input size_fmt_e fmt,
                            input logic [SIZE_W-1:0] sz, input bit noisy);
    logic [7:0] hdr [BLOCK_BYTES];
    logic [7:0] stop;
    int nd;
    for (int i = 0; i < BLOCK_BYTES; i++) hdr[i] = noisy ? 8'($urandom_range(0, 255)) : 8'h00;
    // bytes after the name terminator keep the fill
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (i < nlen) hdr[i] = 8'($urandom_range(1, 255));
      else if (i == nlen) hdr[i] = tsmw_pkg::CH_NUL;
    end
    case (fmt)
      SZ_PLAIN: begin
        for (int i = 0; i < 11; i++) hdr[SIZE_OFFSET + i] = oct_digit(sz, 10 - i);
        hdr[SIZE_OFFSET + 11] = tsmw_pkg::CH_NUL;
      end
      SZ_SPACED: begin
        nd = 1;
        while (nd < 10 && (sz >> (3 * nd)) != 0) nd++;
        for (int i = 0; i < 10 - nd; i++)
          hdr[SIZE_OFFSET + i] = $urandom_range(1) ? tsmw_pkg::CH_SPACE : tsmw_pkg::CH_NUL;
        for (int i = 0; i < nd; i++) hdr[SIZE_OFFSET + 10 - nd + i] = oct_digit(sz, nd - 1 - i);
        hdr[SIZE_OFFSET + 10] = tsmw_pkg::CH_SPACE;
        hdr[SIZE_OFFSET + 11] = tsmw_pkg::CH_NUL;
      end
      SZ_FULL: begin
        for (int i = 0; i < 12; i++) hdr[SIZE_OFFSET + i] = oct_digit(sz, 11 - i);
      end
      SZ_STOPPED: begin
        // digits after the stop byte must not count
        do stop = 8'($urandom_range(0, 255));
        while (stop == tsmw_pkg::CH_NUL || stop == tsmw_pkg::CH_SPACE ||
               (stop >= tsmw_pkg::CH_ZERO && stop <= tsmw_pkg::CH_SEVEN));
        for (int i = 0; i < 6; i++) hdr[SIZE_OFFSET + i] = oct_digit(sz, 5 - i);
        hdr[SIZE_OFFSET + 6] = stop;
        for (int i = 7; i < 12; i++)
          hdr[SIZE_OFFSET + i] = tsmw_pkg::CH_ZERO + 8'($urandom_range(0, 7));
      end
      default: begin
        for (int i = 0; i < 12; i++) hdr[SIZE_OFFSET + i] = 8'($urandom_range(0, 255));
      end
    endcase
    hdr[TYPE_OFFSET] = typ;
    for (int i = 0; i < BLOCK_BYTES; i++) build_q.push_back(hdr[i]);
  endtask

  // hand the built stream to the driver, cut after keep bytes when keep is set
  task automatic close_stream(input int keep);
    stream_word_t w;
    if (keep <= 0 || keep > build_q.size()) keep = build_q.size();
    for (int i = 0; i < keep; i++) begin
      w.data = build_q[i];
      w.last = (i == keep - 1);
      stream_words.push_back(w);
    end
    build_q.delete();
  endtask

  // idling phases follow the number of bytes taken
  function automatic int send_idle_pct();
    case ((bytes_accepted / PHASE_BYTES) % 4)
      1:       return 49;
      3:       return 20;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case ((bytes_accepted / PHASE_BYTES) % 4)
      2:       return 49;
      3:       return 20;
      default: return 0;
    endcase
  endfunction

  // stimulus and end of run
  initial begin
    walker_reset();

    // single byte stream: name byte then short-stream error
    build_q.push_back(8'h41);
    close_stream(0);
    // full-length name on a kept member of the largest size, stream ends in its data
    put_header(NAME_BYTES, tsmw_pkg::CH_ZERO, SZ_FULL, SIZE_ALL_ONES, 1'b1);
    build_q.push_back(8'h00);
    build_q.push_back(8'hFF);
    put_random(BLOCK_BYTES - 2);
    close_stream(0);
    // end-of-archive block with junk behind it, still under two blocks
    put_zero_blocks(1);
    put_random(2);
    close_stream(0);
    cycle_limit = 40 * stream_words.size() + 20000;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (stream_words.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // driver: a new word once the last one was taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || byte_taken) begin
        if (stream_words.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          next_word = stream_words.pop_front();
          in_valid_i  <= 1'b1;
          data_byte_i <= next_word.data;
          last_byte_i <= next_word.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with long hold-offs that back the block up to its input
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
      end else if (holds_done < 2 &&
                   bytes_accepted >= HOLD_START + holds_done * HOLD_SPACING) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct());
    end
  end

  // monitor: predict on each taken input word, check each taken result word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      byte_taken = in_valid_i && !in_stall_o;
      if (byte_taken) begin
        walk_tar_byte(data_byte_i, last_byte_i);
        bytes_accepted++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cycle %0d: unexpected word kind %0d byte %h", cycle_count, kind_o,
                     byte_value_o);
        end else begin
          want = expected_words.pop_front();
          if (kind_o !== want.kind || byte_value_o !== want.byte_value ||
              accepted_o !== want.accepted || member_size_o !== want.member_size ||
              name_length_o !== want.name_length || last_of_member_o !== want.last_of_member ||
              error_code_o !== want.error_code) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"cycle %0d: expected kind %0d byte %h acc %b size %h nlen %0d ",
                        "last %b err %b, got kind %0d byte %h acc %b size %h nlen %0d ",
                        "last %b err %b"},
                       cycle_count, want.kind, want.byte_value, want.accepted,
                       want.member_size, want.name_length, want.last_of_member,
                       want.error_code, kind_o, byte_value_o, accepted_o, member_size_o,
                       name_length_o, last_of_member_o, error_code_o);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
